>>> design/ogm_pkg.sv
// ----------------------------------------------------------------------------
// ogm_pkg
// Shared widths, request and register codes, reset values and the
// command/status structs between the occupancy grid controller and datapath.
// ----------------------------------------------------------------------------
package ogm_pkg;

  localparam int unsigned X_CELLS_DEF = 64;
  localparam int unsigned Y_CELLS_DEF = 64;

  localparam int POS_W      = 24;
  localparam int VAL_W      = 8;
  localparam int REQ_W      = 3;
  localparam int CELL_IDX_W = 6;
  localparam int CFG_IDX_W  = 4;

  // request codes; anything else acts as a read
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INVERT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SET    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 4'd3;

  localparam logic signed [POS_W-1:0] LEFT_RST   = -24'sd2560;
  localparam logic signed [POS_W-1:0] RIGHT_RST  = 24'sd2560;
  localparam logic signed [POS_W-1:0] BOTTOM_RST = -24'sd2560;
  localparam logic signed [POS_W-1:0] TOP_RST    = 24'sd2560;

  localparam logic [VAL_W-1:0] CELL_FULL = 8'hFF;

  typedef struct packed {
    logic load;       // capture request word
    logic check;      // bounds check, offsets and spans
    logic mul;        // scale offsets by cell counts
    logic div_start;  // launch divider
    logic div_sel_y;  // divider works on y axis
    logic cap_x;      // capture x index
    logic cap_y;      // capture y index
    logic addr;       // form cell address
    logic rd;         // read cell
    logic wr;         // write cell back
    logic clr;        // clearing pass write
    logic out_load;   // load response register
  } ogm_cmd_t;

  typedef struct packed {
    logic oor;
    logic div_done;
    logic clr_last;
  } ogm_sts_t;

endpackage

>>> design/ogm_if.sv
// ----------------------------------------------------------------------------
// ogm interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ogm_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ogm_pkg::REQ_W-1:0]     req_type;
  logic signed [ogm_pkg::POS_W-1:0]     pos_x;
  logic signed [ogm_pkg::POS_W-1:0]     pos_y;
  logic        [ogm_pkg::VAL_W-1:0]     write_value;

  modport source (output valid, req_type, pos_x, pos_y, write_value, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, write_value, output ready);
endinterface

interface ogm_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [ogm_pkg::VAL_W-1:0]            cell_value;
  logic                                 cell_free;
  logic                                 out_of_range;
  logic [ogm_pkg::CELL_IDX_W-1:0]       cell_x;
  logic [ogm_pkg::CELL_IDX_W-1:0]       cell_y;

  modport source (output valid, cell_value, cell_free, out_of_range, cell_x, cell_y,
                  input ready);
  modport sink   (input valid, cell_value, cell_free, out_of_range, cell_x, cell_y,
                  output ready);
endinterface

interface ogm_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ogm_pkg::CFG_IDX_W-1:0] index;
  logic signed [ogm_pkg::POS_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/occupancy_grid_map_top.sv
// ----------------------------------------------------------------------------
// occupancy_grid_map_top
// Two-dimensional 8-bit occupancy grid addressed by fixed-point positions.
// ----------------------------------------------------------------------------
// After reset the block clears the grid, one cell per cycle, all
// X_CELLS*Y_CELLS cells (4096 by default); requests wait during that pass,
// register writes are taken. It then works on one request at a time. For a
// request in range it checks the bounds and scales the offsets; each axis
// index then comes from one shared restoring divider that makes one quotient
// bit per cycle, followed by a read and a write of the grid RAM. For a
// request out of the bounds the divider and the grid are left alone. Either
// way the response register is loaded once the output register is free. A
// new request is accepted in the cycle after the previous response is
// loaded into the output register.
module occupancy_grid_map_top #(
  parameter int unsigned X_CELLS = ogm_pkg::X_CELLS_DEF,
  parameter int unsigned Y_CELLS = ogm_pkg::Y_CELLS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ogm_req_if.sink      req_i,
  ogm_rsp_if.source    rsp_o,
  ogm_cfg_if.sink      cfg_i
);
  import ogm_pkg::*;

  ogm_cmd_t cmd;
  ogm_sts_t sts;
  logic     cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  ogm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ogm_dp #(.X_CELLS(X_CELLS), .Y_CELLS(Y_CELLS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .req_type_i     (req_i.req_type),
    .pos_x_i        (req_i.pos_x),
    .pos_y_i        (req_i.pos_y),
    .write_value_i  (req_i.write_value),
    .cell_value_o   (rsp_o.cell_value),
    .cell_free_o    (rsp_o.cell_free),
    .out_of_range_o (rsp_o.out_of_range),
    .cell_x_o       (rsp_o.cell_x),
    .cell_y_o       (rsp_o.cell_y)
  );

  // write-back always follows the read of the same request
  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> $past(cmd.rd))
    else $error("grid write without preceding read");

  // no request enters while the clearing pass runs
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> !req_i.ready)
    else $error("request accepted during clearing pass");

  // a loaded response is presented in the next cycle
  a_rsp_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> rsp_o.valid)
    else $error("response loaded but not valid");

endmodule

>>> design/ogm_ram.sv
// ----------------------------------------------------------------------------
// ogm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ogm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ogm_div.sv
// ----------------------------------------------------------------------------
// ogm_div
// Restoring divider, one quotient bit per cycle. The caller guarantees
// num < den * 2**QW, so only QW steps are needed.
// ----------------------------------------------------------------------------
module ogm_div #(
  parameter int unsigned QW = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ogm_pkg::POS_W+QW-1:0]   num_i,
  input  logic [ogm_pkg::POS_W-1:0]      den_i,
  output logic                           done_o,
  output logic [QW-1:0]                  quo_o
);
  import ogm_pkg::*;

  localparam int unsigned CNTW = $clog2(QW + 1);

  logic [POS_W-1:0] rem_q, rem_d;
  logic [QW-1:0]    sh_q, sh_d;     // numerator bits out at top, quotient bits in at bottom
  logic [CNTW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [POS_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, sh_q[QW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
    sh_d  = {sh_q[QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[POS_W+QW-1:QW];
      sh_q  <= num_i[QW-1:0];
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CNTW'(QW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

>>> design/ogm_ctrl.sv
// ----------------------------------------------------------------------------
// ogm_ctrl
// Sequencer for one request: bounds check, scale, two divisions, address,
// read-modify-write, response. Also runs the grid clearing pass after reset.
// ----------------------------------------------------------------------------
module ogm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  ogm_pkg::ogm_sts_t sts_i,
  output ogm_pkg::ogm_cmd_t cmd_o
);
  import ogm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_MUL, S_XS, S_XW, S_YS, S_YW,
    S_ADDR, S_RD, S_MOD, S_DONE
  } state_e;

  state_e    state_q, state_d;
  logic      rsp_valid_q;
  ogm_cmd_t  cmd;
  logic      out_free;

  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_d = sts_i.oor ? S_DONE : S_XS;
      end
      S_XS: begin
        cmd.div_start = 1'b1;
        state_d       = S_XW;
      end
      S_XW: begin
        if (sts_i.div_done) begin
          cmd.cap_x = 1'b1;
          state_d   = S_YS;
        end
      end
      S_YS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
        state_d       = S_YW;
      end
      S_YW: begin
        cmd.div_sel_y = 1'b1;
        if (sts_i.div_done) begin
          cmd.cap_y = 1'b1;
          state_d   = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr = 1'b1;
        state_d  = S_RD;
      end
      S_RD: begin
        cmd.rd  = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        cmd.wr  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd.out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign cmd_o       = cmd;

endmodule

>>> design/ogm_dp.sv
// ----------------------------------------------------------------------------
// ogm_dp
// Datapath: bound registers, request registers, offset/span arithmetic,
// shared divider, address generation, grid RAM and response register.
// ----------------------------------------------------------------------------
module ogm_dp #(
  parameter int unsigned X_CELLS = ogm_pkg::X_CELLS_DEF,
  parameter int unsigned Y_CELLS = ogm_pkg::Y_CELLS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ogm_pkg::ogm_cmd_t                    cmd_i,
  output ogm_pkg::ogm_sts_t                    sts_o,
  input  logic                                 cfg_we_i,
  input  logic        [ogm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic signed [ogm_pkg::POS_W-1:0]     cfg_data_i,
  input  logic        [ogm_pkg::REQ_W-1:0]     req_type_i,
  input  logic signed [ogm_pkg::POS_W-1:0]     pos_x_i,
  input  logic signed [ogm_pkg::POS_W-1:0]     pos_y_i,
  input  logic        [ogm_pkg::VAL_W-1:0]     write_value_i,
  output logic        [ogm_pkg::VAL_W-1:0]     cell_value_o,
  output logic                                 cell_free_o,
  output logic                                 out_of_range_o,
  output logic        [ogm_pkg::CELL_IDX_W-1:0] cell_x_o,
  output logic        [ogm_pkg::CELL_IDX_W-1:0] cell_y_o
);
  import ogm_pkg::*;

  localparam int unsigned XW    = $clog2(X_CELLS);
  localparam int unsigned YW    = $clog2(Y_CELLS);
  localparam int unsigned DEPTH = X_CELLS * Y_CELLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  // quotient can reach CELLS itself before the clamp
  localparam int unsigned DQW   = (XW > YW) ? XW + 1 : YW + 1;
  localparam int unsigned NUMW  = POS_W + DQW;

  // bounds
  logic signed [POS_W-1:0] lx_q, hx_q, ly_q, hy_q;

  // request
  logic        [REQ_W-1:0] req_q;
  logic signed [POS_W-1:0] px_q, py_q;
  logic        [VAL_W-1:0] wval_q;

  logic                    oor_q;
  logic [POS_W-1:0]        off_x_q, off_y_q, span_x_q, span_y_q;
  logic [NUMW-1:0]         num_x_q, num_y_q;
  logic [XW-1:0]           cx_q;
  logic [YW-1:0]           cy_q;
  logic [AW-1:0]           addr_q;
  logic [AW-1:0]           clr_cnt_q;
  logic [VAL_W-1:0]        res_q;

  logic [VAL_W-1:0]        out_val_q;
  logic                    out_free_q, out_oor_q;
  logic [CELL_IDX_W-1:0]   out_cx_q, out_cy_q;

  logic signed [POS_W:0]   dx, dy, sx, sy;
  logic                    oor_d;
  logic                    div_done;
  logic [DQW-1:0]          quo;
  logic [NUMW-1:0]         div_num;
  logic [POS_W-1:0]        div_den;
  logic [XW-1:0]           cx_d;
  logic [YW-1:0]           cy_d;
  logic [VAL_W-1:0]        rdata, new_val;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [VAL_W-1:0]        ram_wdata;
  logic [XW+CELL_IDX_W-1:0] cx_ext;
  logic [YW+CELL_IDX_W-1:0] cy_ext;

  // bound registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= LEFT_RST;
      hx_q <= RIGHT_RST;
      ly_q <= BOTTOM_RST;
      hy_q <= TOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LEFT:   lx_q <= cfg_data_i;
        CFG_RIGHT:  hx_q <= cfg_data_i;
        CFG_BOTTOM: ly_q <= cfg_data_i;
        CFG_TOP:    hy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // bounds check and offsets; offsets and spans only matter when in range
  always_comb begin
    dx    = {px_q[POS_W-1], px_q} - {lx_q[POS_W-1], lx_q};
    dy    = {py_q[POS_W-1], py_q} - {ly_q[POS_W-1], ly_q};
    sx    = {hx_q[POS_W-1], hx_q} - {lx_q[POS_W-1], lx_q};
    sy    = {hy_q[POS_W-1], hy_q} - {ly_q[POS_W-1], ly_q};
    oor_d = (px_q < lx_q) || (px_q > hx_q) || (py_q < ly_q) || (py_q > hy_q);
  end

  assign div_num = cmd_i.div_sel_y ? num_y_q : num_x_q;
  assign div_den = cmd_i.div_sel_y ? span_y_q : span_x_q;

  ogm_div #(.QW(DQW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // zero span: the only in-range position sits on the bound, index 0
  always_comb begin
    if (span_x_q == '0) begin
      cx_d = '0;
    end else if (quo > DQW'(X_CELLS - 1)) begin
      cx_d = XW'(X_CELLS - 1);
    end else begin
      cx_d = XW'(quo);
    end
    if (span_y_q == '0) begin
      cy_d = '0;
    end else if (quo > DQW'(Y_CELLS - 1)) begin
      cy_d = YW'(Y_CELLS - 1);
    end else begin
      cy_d = YW'(quo);
    end
  end

  always_comb begin
    case (req_q)
      REQ_READ:   new_val = rdata;
      REQ_INVERT: new_val = ~rdata;
      REQ_CLEAR:  new_val = '0;
      REQ_SET:    new_val = CELL_FULL;
      REQ_WRITE:  new_val = wval_q;
      default:    new_val = rdata;
    endcase
  end

  assign ram_we    = cmd_i.clr || cmd_i.wr;
  assign ram_waddr = cmd_i.clr ? clr_cnt_q : addr_q;
  assign ram_wdata = cmd_i.clr ? '0 : new_val;

  ogm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      wval_q <= write_value_i;
    end
    if (cmd_i.check) begin
      oor_q    <= oor_d;
      off_x_q  <= dx[POS_W-1:0];
      off_y_q  <= dy[POS_W-1:0];
      span_x_q <= sx[POS_W-1:0];
      span_y_q <= sy[POS_W-1:0];
    end
    if (cmd_i.mul) begin
      num_x_q <= NUMW'(off_x_q) * NUMW'(X_CELLS);
      num_y_q <= NUMW'(off_y_q) * NUMW'(Y_CELLS);
    end
    if (cmd_i.cap_x) begin
      cx_q <= cx_d;
    end
    if (cmd_i.cap_y) begin
      cy_q <= cy_d;
    end
    if (cmd_i.addr) begin
      addr_q <= AW'(cx_q) * AW'(Y_CELLS) + AW'(cy_q);
    end
    if (cmd_i.wr) begin
      res_q <= new_val;
    end
  end

  assign cx_ext = (XW + CELL_IDX_W)'(cx_q);
  assign cy_ext = (YW + CELL_IDX_W)'(cy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (oor_q) begin
        out_val_q  <= '0;
        out_free_q <= 1'b0;
        out_oor_q  <= 1'b1;
        out_cx_q   <= '0;
        out_cy_q   <= '0;
      end else begin
        out_val_q  <= res_q;
        out_free_q <= (res_q == '0);
        out_oor_q  <= 1'b0;
        out_cx_q   <= cx_ext[CELL_IDX_W-1:0];
        out_cy_q   <= cy_ext[CELL_IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign sts_o.oor      = oor_q;
  assign sts_o.div_done = div_done;
  assign sts_o.clr_last = (clr_cnt_q == AW'(DEPTH - 1));

  assign cell_value_o   = out_val_q;
  assign cell_free_o    = out_free_q;
  assign out_of_range_o = out_oor_q;
  assign cell_x_o       = out_cx_q;
  assign cell_y_o       = out_cy_q;

endmodule

>>> tb/sv/occupancy_grid_map_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_map_top_tb
// Self-checking bench: a shadow copy of the grid and the bounds predicts every
// response word. Directed requests cover each operation, bound edges and odd
// bound settings. Random requests follow under several bound settings, with
// random idling on both channels and one long response stall.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [ogm_pkg::REQ_W-1:0]        req_type;
  logic signed [ogm_pkg::POS_W-1:0] pos_x;
  logic signed [ogm_pkg::POS_W-1:0] pos_y;
  logic [ogm_pkg::VAL_W-1:0]        write_value;
} grid_req_t;

typedef struct packed {
  logic [ogm_pkg::VAL_W-1:0]      cell_value;
  logic                           cell_free;
  logic                           out_of_range;
  logic [ogm_pkg::CELL_IDX_W-1:0] cell_x;
  logic [ogm_pkg::CELL_IDX_W-1:0] cell_y;
} grid_rsp_t;

class grid_shadow;
  logic [ogm_pkg::VAL_W-1:0]        cells [ogm_pkg::X_CELLS_DEF * ogm_pkg::Y_CELLS_DEF];
  logic signed [ogm_pkg::POS_W-1:0] bounds [4];
  grid_rsp_t                        pending_rsp [$];
  int                               errors;

  function new();
    foreach (cells[i]) cells[i] = '0;
    bounds[ogm_pkg::CFG_LEFT]   = ogm_pkg::LEFT_RST;
    bounds[ogm_pkg::CFG_RIGHT]  = ogm_pkg::RIGHT_RST;
    bounds[ogm_pkg::CFG_BOTTOM] = ogm_pkg::BOTTOM_RST;
    bounds[ogm_pkg::CFG_TOP]    = ogm_pkg::TOP_RST;
    errors = 0;
  endfunction

  function void write_bound(logic [ogm_pkg::CFG_IDX_W-1:0] idx,
                            logic signed [ogm_pkg::POS_W-1:0] data);
    if (idx <= ogm_pkg::CFG_TOP) bounds[idx[1:0]] = data;
  endfunction

  // floor(offset * n / span), clamped to n-1; caller ensures lo <= p <= hi
  function longint cell_index(longint p, longint lo, longint hi, longint n);
    longint span;
    longint idx;
    span = hi - lo;
    if (span == 0) return 0;
    idx = ((p - lo) * n) / span;
    if (idx > n - 1) idx = n - 1;
    return idx;
  endfunction

  function void apply_request(grid_req_t r);
    longint px, py, lx, hx, ly, hy, cx, cy, addr;
    logic [ogm_pkg::VAL_W-1:0] v;
    grid_rsp_t e;
    px = $signed(r.pos_x);
    py = $signed(r.pos_y);
    lx = bounds[ogm_pkg::CFG_LEFT];
    hx = bounds[ogm_pkg::CFG_RIGHT];
    ly = bounds[ogm_pkg::CFG_BOTTOM];
    hy = bounds[ogm_pkg::CFG_TOP];
    e = '0;
    if (px < lx || px > hx || py < ly || py > hy) begin
      e.out_of_range = 1'b1;
    end else begin
      cx = cell_index(px, lx, hx, ogm_pkg::X_CELLS_DEF);
      cy = cell_index(py, ly, hy, ogm_pkg::Y_CELLS_DEF);
      addr = cx * ogm_pkg::Y_CELLS_DEF + cy;
      v = cells[addr];
      case (r.req_type)
        ogm_pkg::REQ_INVERT: v = ~v;
        ogm_pkg::REQ_CLEAR:  v = '0;
        ogm_pkg::REQ_SET:    v = ogm_pkg::CELL_FULL;
        ogm_pkg::REQ_WRITE:  v = r.write_value;
        default: ;  // read, and undefined codes act as read
      endcase
      cells[addr] = v;
      e.cell_value = v;
      e.cell_free  = (v == '0);
      e.cell_x     = cx[ogm_pkg::CELL_IDX_W-1:0];
      e.cell_y     = cy[ogm_pkg::CELL_IDX_W-1:0];
    end
    pending_rsp.push_back(e);
  endfunction

  function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  function void check_response(grid_rsp_t a);
    grid_rsp_t e;
    if (pending_rsp.size() == 0) begin
      errors++;
      $display("%0t: unexpected response word: expected none actual %h", $time, a);
      return;
    end
    e = pending_rsp.pop_front();
    compare_field("cell_value", 32'(e.cell_value), 32'(a.cell_value));
    compare_field("cell_free", 32'(e.cell_free), 32'(a.cell_free));
    compare_field("out_of_range", 32'(e.out_of_range), 32'(a.out_of_range));
    compare_field("cell_x", 32'(e.cell_x), 32'(a.cell_x));
    compare_field("cell_y", 32'(e.cell_y), 32'(a.cell_y));
  endfunction
endclass

module occupancy_grid_map_top_tb;

  localparam int CLK_HALF     = 10;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RSP_HOLD     = 300;
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [ogm_pkg::POS_W-1:0] POS_MIN = {1'b1, {(ogm_pkg::POS_W-1){1'b0}}};
  localparam logic signed [ogm_pkg::POS_W-1:0] POS_MAX = {1'b0, {(ogm_pkg::POS_W-1){1'b1}}};
  localparam logic [ogm_pkg::REQ_W-1:0]      REQ_UNDEF  = '1;
  localparam logic [ogm_pkg::CFG_IDX_W-1:0]  CFG_UNUSED = '1;

  logic clk_i;
  logic rst_ni;

  ogm_req_if req_if ();
  ogm_rsp_if rsp_if ();
  ogm_cfg_if cfg_if ();

  grid_shadow sb = new();

  bit no_idle  = 1'b0;
  bit hold_rsp = 1'b0;
  int unsigned cycles = 0;

  logic signed [ogm_pkg::POS_W-1:0] hist_x [$];
  logic signed [ogm_pkg::POS_W-1:0] hist_y [$];

  occupancy_grid_map_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [ogm_pkg::POS_W-1:0] pick_coord(longint lo, longint hi);
    int unsigned r;
    longint v;
    longint t;
    r = $urandom_range(0, 99);
    if (hi < lo) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    if (r < 68)      v = lo + longint'($urandom) % (hi - lo + 1);
    else if (r < 78) v = r[0] ? lo : hi;
    else if (r < 84) v = r[0] ? lo - 1 : hi + 1;
    else if (r < 94) v = longint'($urandom);
    else             v = r[0] ? longint'(POS_MIN) : longint'(POS_MAX);
    return v[ogm_pkg::POS_W-1:0];
  endfunction

  task automatic send_req(input logic [ogm_pkg::REQ_W-1:0] op,
                          input logic signed [ogm_pkg::POS_W-1:0] x,
                          input logic signed [ogm_pkg::POS_W-1:0] y,
                          input logic [ogm_pkg::VAL_W-1:0] wv);
    int g;
    g = idle_gap();
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= op;
    req_if.pos_x       <= x;
    req_if.pos_y       <= y;
    req_if.write_value <= wv;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_bounds(input logic signed [ogm_pkg::POS_W-1:0] l,
                            input logic signed [ogm_pkg::POS_W-1:0] r,
                            input logic signed [ogm_pkg::POS_W-1:0] b,
                            input logic signed [ogm_pkg::POS_W-1:0] t,
                            input bit poke_unused);
    logic [ogm_pkg::CFG_IDX_W-1:0]    idx [5];
    logic signed [ogm_pkg::POS_W-1:0] val [5];
    idx[0] = CFG_UNUSED;          val[0] = ogm_pkg::POS_W'($urandom);
    idx[1] = ogm_pkg::CFG_LEFT;   val[1] = l;
    idx[2] = ogm_pkg::CFG_RIGHT;  val[2] = r;
    idx[3] = ogm_pkg::CFG_BOTTOM; val[3] = b;
    idx[4] = ogm_pkg::CFG_TOP;    val[4] = t;
    wait_drained();
    for (int i = poke_unused ? 0 : 1; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic pick_span(output logic signed [ogm_pkg::POS_W-1:0] lo,
                           output logic signed [ogm_pkg::POS_W-1:0] hi);
    longint a;
    longint w;
    longint e;
    int unsigned r;
    r = $urandom_range(0, 99);
    a = longint'($urandom_range(0, 16777215)) - 8388608;
    if (r < 50)      w = longint'($urandom_range(1, 63));
    else if (r < 80) w = longint'($urandom_range(64, 20000));
    else             w = longint'($urandom_range(20000, 16777215));
    e = a + w;
    if (e > 8388607) e = 8388607;
    lo = a[ogm_pkg::POS_W-1:0];
    hi = e[ogm_pkg::POS_W-1:0];
  endtask

  task automatic run_random(input int n, input int hold_at);
    logic [ogm_pkg::REQ_W-1:0]        op;
    logic signed [ogm_pkg::POS_W-1:0] x, y;
    int k;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_rsp = 1'b1;
      op = ($urandom_range(0, 99) < 90)
           ? ogm_pkg::REQ_W'($urandom_range(ogm_pkg::REQ_READ, ogm_pkg::REQ_WRITE))
           : ogm_pkg::REQ_W'($urandom_range(ogm_pkg::REQ_WRITE + 1, REQ_UNDEF));
      // revisit recent cells so that stored values get read back
      if (hist_x.size() > 0 && $urandom_range(0, 99) < 45) begin
        k = $urandom_range(0, hist_x.size() - 1);
        x = hist_x[k];
        y = hist_y[k];
      end else begin
        x = pick_coord(sb.bounds[ogm_pkg::CFG_LEFT], sb.bounds[ogm_pkg::CFG_RIGHT]);
        y = pick_coord(sb.bounds[ogm_pkg::CFG_BOTTOM], sb.bounds[ogm_pkg::CFG_TOP]);
        hist_x.push_back(x);
        hist_y.push_back(y);
        if (hist_x.size() > 16) begin
          void'(hist_x.pop_front());
          void'(hist_y.pop_front());
        end
      end
      send_req(op, x, y, ogm_pkg::VAL_W'($urandom));
    end
  endtask

  // response side: random ready, one long hold on request
  initial begin : rsp_sink
    int g;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      g = idle_gap();
      if (g > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // result checked before the same-edge request is noted
  always @(posedge clk_i) begin : watch
    grid_rsp_t got;
    grid_req_t took;
    if (rst_ni) begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got.cell_value   = rsp_if.cell_value;
        got.cell_free    = rsp_if.cell_free;
        got.out_of_range = rsp_if.out_of_range;
        got.cell_x       = rsp_if.cell_x;
        got.cell_y       = rsp_if.cell_y;
        sb.check_response(got);
      end
      if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
        took.req_type    = req_if.req_type;
        took.pos_x       = req_if.pos_x;
        took.pos_y       = req_if.pos_y;
        took.write_value = req_if.write_value;
        sb.apply_request(took);
      end
      if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
        sb.write_bound(cfg_if.index, cfg_if.data);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("** occupancy_grid_map_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic signed [ogm_pkg::POS_W-1:0] l, r, b, t;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= ogm_pkg::REQ_READ;
    req_if.pos_x       <= '0;
    req_if.pos_y       <= '0;
    req_if.write_value <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= ogm_pkg::CFG_LEFT;
    cfg_if.data        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset bounds: +-10.0, 80 units per cell
    send_req(ogm_pkg::REQ_READ,   '0, '0, 8'h00);
    send_req(ogm_pkg::REQ_SET,    '0, '0, 8'h00);
    send_req(ogm_pkg::REQ_INVERT, '0, '0, 8'h00);
    send_req(ogm_pkg::REQ_INVERT, '0, '0, 8'h00);
    send_req(ogm_pkg::REQ_CLEAR,  '0, '0, 8'h00);
    send_req(ogm_pkg::REQ_WRITE,  '0, '0, 8'hA5);
    send_req(REQ_UNDEF,           '0, '0, 8'h3C);
    send_req(ogm_pkg::REQ_WRITE,  ogm_pkg::RIGHT_RST, ogm_pkg::TOP_RST, 8'hFF);
    send_req(ogm_pkg::REQ_WRITE,  ogm_pkg::LEFT_RST, ogm_pkg::BOTTOM_RST, 8'h00);
    send_req(ogm_pkg::REQ_READ,   ogm_pkg::LEFT_RST - 1, '0, 8'h00);
    send_req(ogm_pkg::REQ_READ,   '0, ogm_pkg::TOP_RST + 1, 8'h00);
    send_req(ogm_pkg::REQ_SET,    POS_MIN, POS_MAX, 8'h00);
    send_req(ogm_pkg::REQ_WRITE,  POS_MAX, POS_MIN, 8'h77);
    send_req(ogm_pkg::REQ_READ,   ogm_pkg::RIGHT_RST - 1, -24'sd1, 8'h00);

    // widest span
    set_bounds(POS_MIN, POS_MAX, POS_MIN, POS_MAX, 1'b1);
    send_req(ogm_pkg::REQ_WRITE,  POS_MIN, POS_MIN, 8'h5A);
    send_req(ogm_pkg::REQ_SET,    POS_MAX, POS_MAX, 8'h00);
    send_req(ogm_pkg::REQ_READ,   '0, '0, 8'h00);

    // upper below lower: nothing in range
    set_bounds(24'sd100, -24'sd100, 24'sd100, -24'sd100, 1'b0);
    send_req(ogm_pkg::REQ_READ,   '0, '0, 8'h00);
    send_req(ogm_pkg::REQ_SET,    24'sd100, -24'sd100, 8'h00);

    // zero span on both axes
    set_bounds(24'sd256, 24'sd256, -24'sd256, -24'sd256, 1'b0);
    send_req(ogm_pkg::REQ_INVERT, 24'sd256, -24'sd256, 8'h00);
    send_req(ogm_pkg::REQ_READ,   24'sd257, -24'sd256, 8'h00);
    send_req(ogm_pkg::REQ_READ,   24'sd256, -24'sd255, 8'h00);

    set_bounds(ogm_pkg::LEFT_RST, ogm_pkg::RIGHT_RST, ogm_pkg::BOTTOM_RST,
               ogm_pkg::TOP_RST, 1'b0);
    run_random(150, 40);

    set_bounds(POS_MIN, POS_MAX, POS_MIN, POS_MAX, 1'b0);
    run_random(100, -1);

    // tiny spans, no idling on either side
    no_idle = 1'b1;
    set_bounds(24'sd0, 24'sd1, -24'sd3, 24'sd60, 1'b0);
    run_random(100, -1);
    no_idle = 1'b0;

    for (int p = 0; p < 2; p++) begin
      pick_span(l, r);
      pick_span(b, t);
      set_bounds(l, r, b, t, 1'b1);
      run_random(100, -1);
    end

    set_bounds(POS_MAX, POS_MIN, 24'sd5, -24'sd5, 1'b0);
    run_random(25, -1);
    set_bounds(-24'sd7, -24'sd7, POS_MAX, POS_MAX, 1'b0);
    run_random(25, -1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("** occupancy_grid_map_top: PASSED **");
    end else begin
      $display("** occupancy_grid_map_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ogm_pkg.sv
design/ogm_if.sv
design/ogm_ram.sv
design/ogm_div.sv
design/ogm_ctrl.sv
design/ogm_dp.sv
design/occupancy_grid_map_top.sv
tb/sv/occupancy_grid_map_top_tb.sv
